FILE: src/pli_pkg.sv
// Shared types, codes and the control store for the piecewise linear interpolator.
// Depends on nothing; the datapath, sequencer and top level import it.
`default_nettype none
package pli_pkg;

   localparam int KNOT_INDEX_W = 6;
   localparam int KNOT_SLOTS   = 2 ** KNOT_INDEX_W;
   localparam int PC_W         = 5;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_EQUAL = 2'd2;

   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type PC_IDLE     = 5'd0;
   localparam pc_type PC_BEGIN    = 5'd1;
   localparam pc_type PC_X0       = 5'd2;
   localparam pc_type PC_SCAN     = 5'd3;
   localparam pc_type PC_DECIDE   = 5'd4;
   localparam pc_type PC_READ_YR  = 5'd5;
   localparam pc_type PC_DIFF     = 5'd6;
   localparam pc_type PC_MUL_LO   = 5'd7;
   localparam pc_type PC_MUL_HI   = 5'd8;
   localparam pc_type PC_ACC      = 5'd9;
   localparam pc_type PC_DIV_INIT = 5'd10;
   localparam pc_type PC_DIV      = 5'd11;
   localparam pc_type PC_SUM      = 5'd12;
   localparam pc_type PC_CLAMP    = 5'd13;
   localparam pc_type PC_EMPTY    = 5'd14;
   localparam pc_type PC_PUSH     = 5'd15;
   localparam pc_type PC_LOAD     = 5'd16;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_IDLE,
      OP_LOAD,
      OP_BEGIN,
      OP_TAKE_X0,
      OP_SCAN,
      OP_DECIDE,
      OP_READ_YR,
      OP_DIFF,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_ACC,
      OP_DIV_INIT,
      OP_DIV,
      OP_SUM,
      OP_CLAMP,
      OP_EMPTY,
      OP_PUSH
   } op_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_GOTO,
      JMP_IF,
      JMP_WAIT,
      JMP_DISPATCH
   } jump_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_EMPTY,
      COND_SINGLE,
      COND_SCAN_END,
      COND_CLAMP,
      COND_DIV_END,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      op_type   op;
      jump_type jump;
      cond_type cond;
      pc_type   target;
   } ctrl_type;

   typedef struct packed {
      logic empty;
      logic single;
      logic scan_end;
      logic clamp;
      logic div_end;
      logic out_free;
   } flags_type;

   function automatic ctrl_type ucode(pc_type pc);
      ctrl_type c;
      case (pc)
         PC_IDLE:     c = '{OP_IDLE,     JMP_DISPATCH, COND_NONE,     PC_LOAD};
         PC_BEGIN:    c = '{OP_BEGIN,    JMP_IF,       COND_EMPTY,    PC_EMPTY};
         PC_X0:       c = '{OP_TAKE_X0,  JMP_IF,       COND_SINGLE,   PC_DECIDE};
         PC_SCAN:     c = '{OP_SCAN,     JMP_WAIT,     COND_SCAN_END, PC_DECIDE};
         PC_DECIDE:   c = '{OP_DECIDE,   JMP_IF,       COND_CLAMP,    PC_CLAMP};
         PC_READ_YR:  c = '{OP_READ_YR,  JMP_NEXT,     COND_NONE,     PC_IDLE};
         PC_DIFF:     c = '{OP_DIFF,     JMP_NEXT,     COND_NONE,     PC_IDLE};
         PC_MUL_LO:   c = '{OP_MUL_LO,   JMP_NEXT,     COND_NONE,     PC_IDLE};
         PC_MUL_HI:   c = '{OP_MUL_HI,   JMP_NEXT,     COND_NONE,     PC_IDLE};
         PC_ACC:      c = '{OP_ACC,      JMP_NEXT,     COND_NONE,     PC_IDLE};
         PC_DIV_INIT: c = '{OP_DIV_INIT, JMP_NEXT,     COND_NONE,     PC_IDLE};
         PC_DIV:      c = '{OP_DIV,      JMP_WAIT,     COND_DIV_END,  PC_SUM};
         PC_SUM:      c = '{OP_SUM,      JMP_GOTO,     COND_NONE,     PC_PUSH};
         PC_CLAMP:    c = '{OP_CLAMP,    JMP_GOTO,     COND_NONE,     PC_PUSH};
         PC_EMPTY:    c = '{OP_EMPTY,    JMP_NEXT,     COND_NONE,     PC_IDLE};
         PC_PUSH:     c = '{OP_PUSH,     JMP_WAIT,     COND_OUT_FREE, PC_IDLE};
         PC_LOAD:     c = '{OP_LOAD,     JMP_GOTO,     COND_NONE,     PC_IDLE};
         default:     c = '{OP_NOP,      JMP_GOTO,     COND_NONE,     PC_IDLE};
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: src/pli_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the knot x and knot y stores.
`default_nettype none
module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/pli_datapath.sv
// Datapath of the interpolator: knot stores, scan registers, multiplier, divider
// and the result register. Depends on pli_pkg and pli_ram.
`default_nettype none
module pli_datapath import pli_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctrl_type                ctrl,
   input  wire logic                    req_valid,
   input  wire logic [KNOT_INDEX_W-1:0] req_knot_index,
   input  wire logic                    req_knot_last,
   input  wire logic signed [15:0]      req_knot_x,
   input  wire logic signed [31:0]      req_knot_y,
   input  wire logic signed [23:0]      req_query_x,
   input  wire logic                    rsp_stall,
   output flags_type                    flags,
   output logic                         rsp_valid,
   output logic signed [31:0]           rsp_value,
   output logic [1:0]                   rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]           count_ff, count_in;
   logic [KNOT_INDEX_W-1:0] idx_ff, idx_in;
   logic                    last_ff, last_in;
   logic signed [15:0]      kx_ff, kx_in;
   logic signed [31:0]      ky_ff, ky_in;
   logic signed [23:0]      q_ff, q_in;
   logic [CW-1:0]           addr_ff, addr_in;
   logic signed [15:0]      prev_x_ff, prev_x_in;
   logic signed [15:0]      x0_ff, x0_in;
   logic signed [15:0]      xl_ff, xl_in;
   logic signed [15:0]      xr_ff, xr_in;
   logic                    found_ff, found_in;
   logic                    eq_ff, eq_in;
   logic [AW-1:0]           left_ff, left_in;
   logic signed [31:0]      yl_ff, yl_in;
   logic [23:0]             d_ff, d_in;
   logic [15:0]             dx_ff, dx_in;
   logic [32:0]             dyabs_ff, dyabs_in;
   logic                    neg_ff, neg_in;
   logic [40:0]             prod_ff, prod_in;
   logic [56:0]             acc_ff, acc_in;
   logic [23:0]             rem_ff, rem_in;
   logic [32:0]             nsr_ff, nsr_in;
   logic [5:0]              div_cnt_ff, div_cnt_in;
   logic signed [31:0]      res_value_ff, res_value_in;
   logic [1:0]              res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]      rsp_value_ff, rsp_value_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;

   logic                    in_range;
   logic                    wr_en;
   logic [AW-1:0]           rd_addr;
   logic [15:0]             x_rd;
   logic [31:0]             y_rd;
   logic signed [15:0]      x_rd_s;
   logic signed [31:0]      y_rd_s;
   logic signed [24:0]      d_full;
   logic signed [16:0]      dx_full;
   logic signed [32:0]      dy;
   logic [16:0]             mul_b;
   logic [24:0]             trial;
   logic                    ge;
   logic signed [33:0]      sum;
   logic [23:0]             den;

   assign in_range = int'(idx_ff) < DEPTH;
   assign wr_en    = (ctrl.op == OP_LOAD) && in_range;
   assign x_rd_s   = x_rd;
   assign y_rd_s   = y_rd;
   assign den      = {dx_ff, 8'h00};

   pli_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_x_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff[AW-1:0]),
      .wr_data (kx_ff),
      .rd_addr (rd_addr),
      .rd_data (x_rd)
   );

   pli_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_y_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff[AW-1:0]),
      .wr_data (ky_ff),
      .rd_addr (rd_addr),
      .rd_data (y_rd)
   );

   always_comb begin
      flags.empty    = (count_ff == '0);
      flags.single   = (count_ff == CW'(1));
      flags.scan_end = (addr_ff == count_ff);
      flags.clamp    = !found_ff || (q_ff <= $signed({x0_ff, 8'h00}));
      flags.div_end  = (div_cnt_ff == 6'd32);
      flags.out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      case (ctrl.op)
         OP_TAKE_X0, OP_SCAN: rd_addr = addr_ff[AW-1:0];
         OP_DECIDE: begin
            if (!found_ff) begin
               rd_addr = AW'(count_ff - CW'(1));
            end else if (flags.clamp) begin
               rd_addr = '0;
            end else begin
               rd_addr = left_ff;
            end
         end
         OP_READ_YR: rd_addr = left_ff + AW'(1);
         default:    rd_addr = '0;
      endcase
   end

   always_comb begin
      d_full  = 25'(q_ff) - 25'($signed({xl_ff, 8'h00}));
      dx_full = 17'(xr_ff) - 17'(xl_ff);
      dy      = 33'(y_rd_s) - 33'(yl_ff);
      mul_b   = (ctrl.op == OP_MUL_LO) ? dyabs_ff[16:0] : {1'b0, dyabs_ff[32:17]};
      trial   = {rem_ff, nsr_ff[32]};
      ge      = trial >= {1'b0, den};
      if (neg_ff) begin
         sum = 34'(yl_ff) - 34'(nsr_ff);
      end else begin
         sum = 34'(yl_ff) + 34'(nsr_ff);
      end

      count_in      = count_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      kx_in         = kx_ff;
      ky_in         = ky_ff;
      q_in          = q_ff;
      addr_in       = addr_ff;
      prev_x_in     = prev_x_ff;
      x0_in         = x0_ff;
      xl_in         = xl_ff;
      xr_in         = xr_ff;
      found_in      = found_ff;
      eq_in         = eq_ff;
      left_in       = left_ff;
      yl_in         = yl_ff;
      d_in          = d_ff;
      dx_in         = dx_ff;
      dyabs_in      = dyabs_ff;
      neg_in        = neg_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      nsr_in        = nsr_ff;
      div_cnt_in    = div_cnt_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;

      case (ctrl.op)
         OP_IDLE: begin
            if (req_valid) begin
               idx_in  = req_knot_index;
               last_in = req_knot_last;
               kx_in   = req_knot_x;
               ky_in   = req_knot_y;
               q_in    = req_query_x;
            end
         end
         OP_LOAD: begin
            if (in_range && last_ff) begin
               count_in = CW'(idx_ff) + CW'(1);
            end
         end
         OP_BEGIN: begin
            addr_in  = CW'(1);
            found_in = 1'b0;
            eq_in    = 1'b0;
         end
         OP_TAKE_X0: begin
            x0_in     = x_rd_s;
            prev_x_in = x_rd_s;
            addr_in   = addr_ff + CW'(1);
         end
         OP_SCAN: begin
            eq_in     = eq_ff || (x_rd_s == prev_x_ff);
            prev_x_in = x_rd_s;
            addr_in   = addr_ff + CW'(1);
            if (!found_ff && ($signed({x_rd, 8'h00}) >= q_ff)) begin
               found_in = 1'b1;
               left_in  = AW'(addr_ff - CW'(2));
               xl_in    = prev_x_ff;
               xr_in    = x_rd_s;
            end
         end
         OP_DECIDE: begin
            d_in  = d_full[23:0];
            dx_in = dx_full[15:0];
         end
         OP_READ_YR: begin
            yl_in = y_rd_s;
         end
         OP_DIFF: begin
            neg_in   = dy[32];
            dyabs_in = dy[32] ? (~dy + 33'd1) : dy;
         end
         OP_MUL_LO: begin
            prod_in = {17'd0, d_ff} * {24'd0, mul_b};
         end
         OP_MUL_HI: begin
            acc_in  = 57'(prod_ff);
            prod_in = {17'd0, d_ff} * {24'd0, mul_b};
         end
         OP_ACC: begin
            acc_in = acc_ff + {prod_ff[39:0], 17'd0};
         end
         OP_DIV_INIT: begin
            rem_in     = acc_ff[56:33];
            nsr_in     = acc_ff[32:0];
            div_cnt_in = '0;
         end
         OP_DIV: begin
            rem_in     = ge ? 24'(trial - {1'b0, den}) : trial[23:0];
            nsr_in     = {nsr_ff[31:0], ge};
            div_cnt_in = div_cnt_ff + 6'd1;
         end
         OP_SUM: begin
            if ((sum[33] != sum[31]) || (sum[32] != sum[31])) begin
               res_value_in = sum[33] ? VALUE_MIN : VALUE_MAX;
            end else begin
               res_value_in = sum[31:0];
            end
            res_status_in = eq_ff ? STATUS_EQUAL : STATUS_OK;
         end
         OP_CLAMP: begin
            res_value_in  = y_rd_s;
            res_status_in = eq_ff ? STATUS_EQUAL : STATUS_OK;
         end
         OP_EMPTY: begin
            res_value_in  = '0;
            res_status_in = STATUS_EMPTY;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if ((ctrl.op == OP_PUSH) && flags.out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value_ff;
         rsp_status_in = res_status_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      last_ff       <= last_in;
      kx_ff         <= kx_in;
      ky_ff         <= ky_in;
      q_ff          <= q_in;
      addr_ff       <= addr_in;
      prev_x_ff     <= prev_x_in;
      x0_ff         <= x0_in;
      xl_ff         <= xl_in;
      xr_ff         <= xr_in;
      found_ff      <= found_in;
      eq_ff         <= eq_in;
      left_ff       <= left_in;
      yl_ff         <= yl_in;
      d_ff          <= d_in;
      dx_ff         <= dx_in;
      dyabs_ff      <= dyabs_in;
      neg_ff        <= neg_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      nsr_ff        <= nsr_in;
      div_cnt_ff    <= div_cnt_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule
`default_nettype wire

FILE: src/pli_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on pli_pkg for the control word, flags and the program.
`default_nettype none
module pli_sequencer import pli_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   input  wire logic      req_cmd,
   input  wire flags_type flags,
   output ctrl_type       ctrl
);

   pc_type pc_ff, pc_in;
   logic   hit;

   always_comb begin
      ctrl = ucode(pc_ff);
      case (ctrl.cond)
         COND_NONE:     hit = 1'b0;
         COND_EMPTY:    hit = flags.empty;
         COND_SINGLE:   hit = flags.single;
         COND_SCAN_END: hit = flags.scan_end;
         COND_CLAMP:    hit = flags.clamp;
         COND_DIV_END:  hit = flags.div_end;
         COND_OUT_FREE: hit = flags.out_free;
         default:       hit = 1'b0;
      endcase
      case (ctrl.jump)
         JMP_NEXT: pc_in = pc_ff + PC_W'(1);
         JMP_GOTO: pc_in = ctrl.target;
         JMP_IF:   pc_in = hit ? ctrl.target : pc_ff + PC_W'(1);
         JMP_WAIT: pc_in = hit ? ctrl.target : pc_ff;
         JMP_DISPATCH: begin
            if (!req_valid) begin
               pc_in = pc_ff;
            end else if (req_cmd == CMD_LOAD) begin
               pc_in = ctrl.target;
            end else begin
               pc_in = pc_ff + PC_W'(1);
            end
         end
         default: pc_in = PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/piecewise_linear_interpolator.sv
// Piecewise linear interpolator, top level; one request is worked on at a time.
// A load writes the knot; a query reads the knots, one knot per scan cycle, and then clamps
// or takes two multiplier steps and 33 divider steps; an empty table gives the empty status,
// and a held result waits in the hand-over step until the output register is free.
// Synchronous reset clears the knot count, the step counter and the result valid; the knot
// stores are not cleared. Depends on pli_pkg, pli_sequencer and pli_datapath.
`default_nettype none
module piecewise_linear_interpolator import pli_pkg::*; #(
   parameter int MAX_KNOTS = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_cmd,
   input  wire logic [KNOT_INDEX_W-1:0] req_knot_index,
   input  wire logic                    req_knot_last,
   input  wire logic signed [15:0]      req_knot_x,
   input  wire logic signed [31:0]      req_knot_y,
   input  wire logic signed [23:0]      req_query_x,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [31:0]           rsp_value,
   output logic [1:0]                   rsp_status
);

   localparam int DEPTH = (MAX_KNOTS < KNOT_SLOTS) ? MAX_KNOTS : KNOT_SLOTS;

   ctrl_type  ctrl;
   flags_type flags;

   assign req_stall = (ctrl.op != OP_IDLE);

   pli_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .flags     (flags),
      .ctrl      (ctrl)
   );

   pli_datapath #(.DEPTH(DEPTH)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .req_valid      (req_valid),
      .req_knot_index (req_knot_index),
      .req_knot_last  (req_knot_last),
      .req_knot_x     (req_knot_x),
      .req_knot_y     (req_knot_y),
      .req_query_x    (req_query_x),
      .rsp_stall      (rsp_stall),
      .flags          (flags),
      .rsp_valid      (rsp_valid),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status)
   );

`ifndef SYNTHESIS
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == CMD_QUERY) |=> ctrl.op == OP_BEGIN)
      else $error("accepted query did not start the search");

   a_load_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == CMD_LOAD) |=> ctrl.op == OP_LOAD)
      else $error("accepted load did not reach the write step");

   a_push_waits: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_PUSH) && rsp_valid && rsp_stall |=> ctrl.op == OP_PUSH)
      else $error("result handed over while the output register was held");

   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctrl.op == OP_PUSH))
      else $error("result valid raised outside the hand-over step");
`endif

endmodule
`default_nettype wire
